>>> sv/tpra_pkg.sv
// Shared types and constants for the table priority request arbiter.
`default_nettype none

package tpra_pkg;

    localparam int unsigned ENTRIES_DEF        = 128;
    localparam int unsigned PRIORITY_WIDTH_DEF = 16;
    localparam int unsigned CMD_W              = 3;
    localparam int unsigned INDEX_W            = 7;
    localparam int unsigned PRIO_IN_W          = 16;
    localparam int unsigned COUNT_W            = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD      = 3'd0,
        CMD_RAISE     = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_ARBITRATE = 3'd3,
        CMD_QUERY     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]            command;
        logic [INDEX_W-1:0]          entry_index;
        logic signed [PRIO_IN_W-1:0] priority_value;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] pending_count;
        logic [INDEX_W-1:0] winner_index;
        logic               winner_found;
        logic               is_selected;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic clr_req;
        logic clr_sel;
        logic load;
        logic raise;
        logic mark;
    } t_cell_ctrl;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctrl;

endpackage

`default_nettype wire

>>> sv/tpra_cell.sv
// One table entry: priority, request bit and selected bit, shifting in a ring.
`default_nettype none

module tpra_cell #(
    parameter int unsigned PRIORITY_WIDTH = tpra_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire tpra_pkg::t_cell_ctrl        i_ctrl,
    input  wire                              i_hit,
    input  wire                              i_win,
    input  wire logic signed [PRIORITY_WIDTH-1:0] i_load_prio,
    input  wire logic signed [PRIORITY_WIDTH-1:0] i_next_prio,
    input  wire                              i_next_req,
    input  wire                              i_next_sel,
    output logic signed [PRIORITY_WIDTH-1:0] o_prio,
    output logic                             o_req,
    output logic                             o_sel
);

    logic signed [PRIORITY_WIDTH-1:0] r_prio;
    logic signed [PRIORITY_WIDTH-1:0] n_prio;
    logic                             r_req;
    logic                             n_req;
    logic                             r_sel;
    logic                             n_sel;

    always_comb begin
        n_prio = r_prio;
        if (i_ctrl.shift) begin
            n_prio = i_next_prio;
        end else if (i_ctrl.load && i_hit) begin
            n_prio = i_load_prio;
        end

        n_req = r_req;
        if (i_ctrl.clr_req) begin
            n_req = 1'b0;
        end else if (i_ctrl.shift) begin
            n_req = i_next_req;
        end else if (i_ctrl.raise && i_hit) begin
            n_req = 1'b1;
        end

        n_sel = r_sel;
        if (i_ctrl.clr_sel) begin
            n_sel = 1'b0;
        end else if (i_ctrl.shift) begin
            n_sel = i_next_sel;
        end else if (i_ctrl.mark && i_win) begin
            n_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            r_req <= n_req;
            r_sel <= n_sel;
        end
    end

    // priority has no reset: undefined until loaded
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
    end

    assign o_prio = r_prio;
    assign o_req  = r_req;
    assign o_sel  = r_sel;

endmodule

`default_nettype wire

>>> sv/tpra_scan.sv
// Scan unit at the head of the ring: counts requests and tracks the best entry.
`default_nettype none

module tpra_scan #(
    parameter int unsigned ENTRIES        = tpra_pkg::ENTRIES_DEF,
    parameter int unsigned PRIORITY_WIDTH = tpra_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire tpra_pkg::t_scan_ctrl               i_ctrl,
    input  wire logic [$clog2(ENTRIES)-1:0]         i_idx,
    input  wire                                     i_req,
    input  wire logic signed [PRIORITY_WIDTH-1:0]   i_prio,
    output logic                                    o_bcast,
    output logic [tpra_pkg::COUNT_W-1:0]            o_count,
    output logic [$clog2(ENTRIES)-1:0]              o_win,
    output logic                                    o_found
);

    localparam int unsigned SW = $clog2(ENTRIES);

    logic signed [PRIORITY_WIDTH-1:0] r_best;
    logic signed [PRIORITY_WIDTH-1:0] n_best;
    logic [SW-1:0]                    r_win;
    logic [SW-1:0]                    n_win;
    logic                             r_found;
    logic                             n_found;
    logic [tpra_pkg::COUNT_W-1:0]     r_count;
    logic [tpra_pkg::COUNT_W-1:0]     n_count;
    logic                             is_bcast;
    logic                             is_pos;
    logic                             better;

    assign is_bcast = (i_prio == '1);
    assign is_pos   = !i_prio[PRIORITY_WIDTH-1] && (i_prio != '0);
    // strict compare keeps the lower index on a tie
    assign better   = is_pos && (!r_found || (i_prio < r_best));

    assign o_bcast = i_ctrl.step && i_req && is_bcast;

    always_comb begin
        n_best  = r_best;
        n_win   = r_win;
        n_found = r_found;
        n_count = r_count;
        if (i_ctrl.start) begin
            n_win   = '0;
            n_found = 1'b0;
            n_count = '0;
        end else if (i_ctrl.step && i_req) begin
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
            if (better) begin
                n_best  = i_prio;
                n_win   = i_idx;
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_count <= '0;
            r_win   <= '0;
        end else begin
            r_found <= n_found;
            r_count <= n_count;
            r_win   <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_count = r_count;
    assign o_win   = r_win;
    assign o_found = r_found;

endmodule

`default_nettype wire

>>> sv/table_priority_request_arbiter.sv
// Top level: ring of entry cells, head scan unit, command sequencer, output register.
//
//   channel | valid      | ready       | word
//   in      | i_in_valid | o_in_ready  | i_in_word  (command, entry_index, priority_value)
//   out     | o_out_valid| i_out_ready | o_out_word (pending_count, winner_index,
//           |            |             |             winner_found, is_selected)
//
// Load, raise, clear, query and unused codes: one cycle, result valid the next cycle.
// Arbitrate: the ring rotates all ENTRIES entries past the scan unit, one entry per cycle,
// then the mark state marks the winner and registers the result.
// One word is worked at a time; a new word is taken only once the output slot frees.
// Reset clears request bits, selected bits and control; priorities hold until loaded.
// A stalled result blocks new words; the mark state also waits for the output slot to free.
`default_nettype none

module table_priority_request_arbiter #(
    parameter int unsigned ENTRIES        = tpra_pkg::ENTRIES_DEF,
    parameter int unsigned PRIORITY_WIDTH = tpra_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire tpra_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tpra_pkg::t_out_word  o_out_word
);

    localparam int unsigned SW = $clog2(ENTRIES);
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

    tpra_pkg::t_state     r_state;
    tpra_pkg::t_state     n_state;
    logic [SW-1:0]        r_cnt;
    logic [SW-1:0]        n_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    tpra_pkg::t_out_word  r_out_word;
    tpra_pkg::t_out_word  n_out_word;

    tpra_pkg::t_cell_ctrl cell_ctrl;
    tpra_pkg::t_scan_ctrl scan_ctrl;

    logic                 in_accept;
    logic                 out_free;
    logic                 query_hit;
    logic                 bcast;
    logic [tpra_pkg::COUNT_W-1:0] scan_count;
    logic [SW-1:0]        scan_win;
    logic                 scan_found;

    logic signed [PRIORITY_WIDTH-1:0] load_prio;
    logic signed [PRIORITY_WIDTH-1:0] w_prio [ENTRIES];
    logic [ENTRIES-1:0]   w_req;
    logic [ENTRIES-1:0]   w_sel;
    logic [ENTRIES-1:0]   w_query;

    // cut or sign-extend the loaded value to the table width
    assign load_prio = PRIORITY_WIDTH'(i_in_word.priority_value);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == tpra_pkg::ST_IDLE) && out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic hit;
        logic win;
        logic signed [PRIORITY_WIDTH-1:0] next_prio;
        logic next_req;
        logic next_sel;

        assign hit = (32'(i_in_word.entry_index) == 32'(i));
        assign win = (32'(scan_win) == 32'(i));
        assign w_query[i] = hit && w_sel[i];

        if (i == ENTRIES - 1) begin : g_tail
            // head entry wraps to the tail, picking up its broadcast mark
            assign next_prio = w_prio[0];
            assign next_req  = w_req[0];
            assign next_sel  = w_sel[0] || bcast;
        end else begin : g_body
            assign next_prio = w_prio[i+1];
            assign next_req  = w_req[i+1];
            assign next_sel  = w_sel[i+1];
        end

        tpra_cell #(
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl),
            .i_hit       (hit),
            .i_win       (win),
            .i_load_prio (load_prio),
            .i_next_prio (next_prio),
            .i_next_req  (next_req),
            .i_next_sel  (next_sel),
            .o_prio      (w_prio[i]),
            .o_req       (w_req[i]),
            .o_sel       (w_sel[i])
        );
    end

    assign query_hit = |w_query;

    tpra_scan #(
        .ENTRIES        (ENTRIES),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (scan_ctrl),
        .i_idx   (r_cnt),
        .i_req   (w_req[0]),
        .i_prio  (w_prio[0]),
        .o_bcast (bcast),
        .o_count (scan_count),
        .o_win   (scan_win),
        .o_found (scan_found)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        cell_ctrl   = '0;
        scan_ctrl   = '0;
        unique case (r_state)
            tpra_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_out_word = '0;
                    unique case (tpra_pkg::t_cmd'(i_in_word.command))
                        tpra_pkg::CMD_LOAD: begin
                            cell_ctrl.load = 1'b1;
                            n_out_valid    = 1'b1;
                        end
                        tpra_pkg::CMD_RAISE: begin
                            cell_ctrl.raise = 1'b1;
                            n_out_valid     = 1'b1;
                        end
                        tpra_pkg::CMD_CLEAR: begin
                            cell_ctrl.clr_req = 1'b1;
                            n_out_valid       = 1'b1;
                        end
                        tpra_pkg::CMD_ARBITRATE: begin
                            cell_ctrl.clr_sel = 1'b1;
                            scan_ctrl.start   = 1'b1;
                            n_cnt             = '0;
                            n_state           = tpra_pkg::ST_SCAN;
                        end
                        tpra_pkg::CMD_QUERY: begin
                            n_out_word.is_selected = query_hit;
                            n_out_valid            = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            tpra_pkg::ST_SCAN: begin
                cell_ctrl.shift = 1'b1;
                scan_ctrl.step  = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = tpra_pkg::ST_MARK;
                end
            end
            tpra_pkg::ST_MARK: begin
                if (out_free) begin
                    cell_ctrl.mark           = scan_found;
                    n_out_word.pending_count = scan_count;
                    n_out_word.winner_index  = tpra_pkg::INDEX_W'(scan_win);
                    n_out_word.winner_found  = scan_found;
                    n_out_word.is_selected   = 1'b0;
                    n_out_valid              = 1'b1;
                    n_state                  = tpra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpra_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_arb_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_word.command == tpra_pkg::CMD_ARBITRATE))
        |=> (r_state == tpra_pkg::ST_SCAN) && (r_cnt == '0))
        else $error("arbitrate did not start a scan from entry zero");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpra_pkg::ST_SCAN) && (r_cnt == LAST) |=> (r_state == tpra_pkg::ST_MARK))
        else $error("scan did not stop after the last entry");

    a_no_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.winner_found |-> (o_out_word.winner_index == '0))
        else $error("winner index set without a winner");

    a_winner_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.winner_found
        |-> (o_out_word.pending_count != '0) && !o_out_word.is_selected)
        else $error("winner reported with no pending request");

endmodule

`default_nettype wire
